// ----- hdl/lc3b_pkg.sv -----
// ----------------------------------------------------------------------------
// lc3b_pkg
// Shared types and codes for the LC-3b instruction step core.
// ----------------------------------------------------------------------------
package lc3b_pkg;

	localparam logic [1:0] REQ_WR   = 2'd0;
	localparam logic [1:0] REQ_STEP = 2'd1;
	localparam logic [1:0] REQ_RD   = 2'd2;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LDB  = 4'd2;
	localparam logic [3:0] OP_STB  = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDW  = 4'd6;
	localparam logic [3:0] OP_STW  = 4'd7;
	localparam logic [3:0] OP_XOR  = 4'd9;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_SHF  = 4'd13;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [1:0] ADDR_START_PC = 2'd0;
	localparam logic [2:0] CC_RESET = 3'b010;
	localparam logic [2:0] REG_LINK = 3'd7;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HRD,
		ST_EX,
		ST_MEM
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] byte_address;
		logic [15:0] write_word;
	} in_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic        halted;
		logic [15:0] fetched_instruction;
		logic        reg_write;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic [2:0]  cc_nzp;
		logic [15:0] read_word;
	} out_t;

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		if (v == 16'd0) return 3'b010;
		return v[15] ? 3'b100 : 3'b001;
	endfunction

endpackage

// ----- hdl/lc3b_instruction_step.sv -----
// ----------------------------------------------------------------------------
// lc3b_instruction_step
// LC-3b instruction-level core around one synchronous word memory.
// ----------------------------------------------------------------------------
// Input channel (req_valid/req_ready/req) carries memory write, memory read
// and step words; output channel (rsp_valid/rsp_ready/rsp) returns one word
// per input word. start_pc is written over the APB port at address 0.
// A write, an unused request or a halting step is answered straight from
// the idle state; a read passes through a read state; a step fetches and
// executes, with a memory state after execute when it loads, does a byte
// store or takes a trap vector. Registered memory read data sets these steps.
// The next request is taken only in the idle state and only while the
// output register is empty or rsp_ready is high, so no result is overwritten.
// After reset the memory is cleared, one word per cycle, all MEM_WORDS words,
// with req_ready low; registers, PC and flags reset at once.
// A stalled receiver holds the output register and stops new requests.
// MEM_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module lc3b_instruction_step #(
	parameter int MEM_WORDS = 32768,
	parameter int NUM_REGS  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  lc3b_pkg::in_t     req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lc3b_pkg::out_t    rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int RW = $clog2(NUM_REGS);

	lc3b_pkg::state_t state_q, nstate;

	logic [15:0] mem [MEM_WORDS];
	logic [15:0] rdata_q;
	logic        we;
	logic [AW-1:0] wa, ra;
	logic [15:0] wd;
	logic [AW:0] clr_q;

	logic [15:0] rf_q [NUM_REGS];
	logic [15:0] pc_q, start_pc_q;
	logic [2:0]  cc_q;
	logic        started_q, stopped_q;
	logic [15:0] instr_q, ea_q;
	logic        rsp_valid_q;
	lc3b_pkg::out_t rsp_q;

	logic        acc, fin, f_wr, f_cc, f_stop, f_start, pc_ld;
	logic [15:0] f_pc, f_val, f_instr, f_rd, pc_eff;
	logic [RW-1:0] f_idx;

	logic [15:0] ins, base, op2, sx6, pc2, br_t, shf, byte_v;
	logic [3:0]  op;
	logic [RW-1:0] dr;

	assign pready    = 1'b1;
	assign prdata    = {16'd0, start_pc_q};
	assign req_ready = (state_q == lc3b_pkg::ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign acc       = req_valid && req_ready;
	assign pc_eff    = started_q ? pc_q : start_pc_q;

	assign ins  = (state_q == lc3b_pkg::ST_EX) ? rdata_q : instr_q;
	assign op   = ins[15:12];
	assign dr   = RW'(ins[11:9]);
	assign base = rf_q[RW'(ins[8:6])];
	assign op2  = ins[5] ? {{11{ins[4]}}, ins[4:0]} : rf_q[RW'(ins[2:0])];
	assign sx6  = {{10{ins[5]}}, ins[5:0]};
	assign pc2  = pc_q + 16'd2;
	assign br_t = pc2 + {{6{ins[8]}}, ins[8:0], 1'b0};

	always_comb begin
		if (!ins[4])
			shf = base << ins[3:0];
		else if (!ins[5])
			shf = base >> ins[3:0];
		else
			shf = 16'($signed(base) >>> ins[3:0]);
	end

	assign byte_v = ea_q[0] ? {{8{rdata_q[15]}}, rdata_q[15:8]}
		: {{8{rdata_q[7]}}, rdata_q[7:0]};

	always_comb begin
		nstate  = state_q;
		we      = 1'b0;
		wa      = req.byte_address[AW:1];
		wd      = req.write_word;
		ra      = req.byte_address[AW:1];
		fin     = 1'b0;
		f_pc    = pc_q;
		f_wr    = 1'b0;
		f_cc    = 1'b0;
		f_idx   = dr;
		f_val   = 16'd0;
		f_instr = 16'd0;
		f_rd    = 16'd0;
		f_stop  = stopped_q;
		f_start = started_q;
		pc_ld   = 1'b0;
		unique case (state_q)
			lc3b_pkg::ST_CLEAR: begin
				we = 1'b1;
				wa = clr_q[AW-1:0];
				wd = 16'd0;
				if (clr_q == (AW+1)'(MEM_WORDS - 1)) nstate = lc3b_pkg::ST_IDLE;
			end
			lc3b_pkg::ST_IDLE: begin
				if (acc) begin
					priority case (req.req_type)
						lc3b_pkg::REQ_WR: begin
							we  = 1'b1;
							fin = 1'b1;
						end
						lc3b_pkg::REQ_RD: nstate = lc3b_pkg::ST_HRD;
						lc3b_pkg::REQ_STEP: begin
							f_start = 1'b1;
							pc_ld   = 1'b1;
							f_pc    = pc_eff;
							if (stopped_q || pc_eff == 16'd0) begin
								f_stop = 1'b1;
								fin    = 1'b1;
							end else begin
								ra     = pc_eff[AW:1];
								nstate = lc3b_pkg::ST_EX;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			lc3b_pkg::ST_HRD: begin
				fin    = 1'b1;
				f_rd   = rdata_q;
				nstate = lc3b_pkg::ST_IDLE;
			end
			lc3b_pkg::ST_EX: begin
				fin     = 1'b1;
				f_instr = ins;
				f_pc    = pc2;
				nstate  = lc3b_pkg::ST_IDLE;
				unique case (op)
					lc3b_pkg::OP_ADD: begin
						f_val = base + op2; f_wr = 1'b1; f_cc = 1'b1;
					end
					lc3b_pkg::OP_AND: begin
						f_val = base & op2; f_wr = 1'b1; f_cc = 1'b1;
					end
					lc3b_pkg::OP_XOR: begin
						f_val = base ^ op2; f_wr = 1'b1; f_cc = 1'b1;
					end
					lc3b_pkg::OP_SHF: begin
						f_val = shf; f_wr = 1'b1; f_cc = 1'b1;
					end
					lc3b_pkg::OP_LEA: begin
						f_val = br_t; f_wr = 1'b1;
					end
					lc3b_pkg::OP_BR: begin
						if ((ins[11:9] & cc_q) != 3'd0) f_pc = br_t;
					end
					lc3b_pkg::OP_JMP: f_pc = base;
					lc3b_pkg::OP_JSR: begin
						f_pc  = ins[11] ? pc2 + {{4{ins[10]}}, ins[10:0], 1'b0} : base;
						f_idx = RW'(lc3b_pkg::REG_LINK);
						f_val = pc2;
						f_wr  = 1'b1;
					end
					lc3b_pkg::OP_STW: begin
						we = 1'b1;
						wa = AW'(16'(base + {sx6[14:0], 1'b0}) >> 1);
						wd = rf_q[dr];
					end
					lc3b_pkg::OP_LDB, lc3b_pkg::OP_STB: begin
						fin = 1'b0; nstate = lc3b_pkg::ST_MEM;
						ra  = AW'(16'(base + sx6) >> 1);
					end
					lc3b_pkg::OP_LDW: begin
						fin = 1'b0; nstate = lc3b_pkg::ST_MEM;
						ra  = AW'(16'(base + {sx6[14:0], 1'b0}) >> 1);
					end
					lc3b_pkg::OP_TRAP: begin
						fin = 1'b0; nstate = lc3b_pkg::ST_MEM;
						ra  = AW'(ins[7:0]);
					end
					default: ;
				endcase
			end
			lc3b_pkg::ST_MEM: begin
				fin     = 1'b1;
				f_instr = ins;
				nstate  = lc3b_pkg::ST_IDLE;
				unique case (op)
					lc3b_pkg::OP_LDB: begin
						f_val = byte_v; f_wr = 1'b1; f_cc = 1'b1;
					end
					lc3b_pkg::OP_LDW: begin
						f_val = rdata_q; f_wr = 1'b1; f_cc = 1'b1;
					end
					lc3b_pkg::OP_STB: begin
						we = 1'b1;
						wa = ea_q[AW:1];
						wd = ea_q[0] ? {rf_q[dr][7:0], rdata_q[7:0]}
							: {rdata_q[15:8], rf_q[dr][7:0]};
					end
					default: begin
						f_pc  = rdata_q;
						f_idx = RW'(lc3b_pkg::REG_LINK);
						f_val = pc_q;
						f_wr  = 1'b1;
					end
				endcase
			end
			default: nstate = lc3b_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == lc3b_pkg::ST_EX) begin
			instr_q <= rdata_q;
			ea_q    <= (op == lc3b_pkg::OP_LDW) ? 16'(base + {sx6[14:0], 1'b0})
				: 16'(base + sx6);
		end
		if (fin) begin
			rsp_q.next_pc             <= f_pc;
			rsp_q.halted              <= f_stop;
			rsp_q.fetched_instruction <= f_instr;
			rsp_q.reg_write           <= f_wr;
			rsp_q.reg_index           <= f_wr ? 3'(f_idx) : 3'd0;
			rsp_q.reg_value           <= f_wr ? f_val : 16'd0;
			rsp_q.cc_nzp              <= f_cc ? lc3b_pkg::flags_of(f_val) : cc_q;
			rsp_q.read_word           <= f_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lc3b_pkg::ST_CLEAR;
			clr_q       <= '0;
			pc_q        <= 16'd0;
			start_pc_q  <= 16'd0;
			cc_q        <= lc3b_pkg::CC_RESET;
			started_q   <= 1'b0;
			stopped_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= 16'd0;
		end else begin
			state_q <= nstate;
			if (state_q == lc3b_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (psel && penable && pwrite && paddr == lc3b_pkg::ADDR_START_PC)
				start_pc_q <= pwdata[15:0];
			started_q <= f_start;
			stopped_q <= f_stop;
			if (pc_ld || (fin && state_q != lc3b_pkg::ST_IDLE
				&& state_q != lc3b_pkg::ST_HRD))
				pc_q <= f_pc;
			else if (state_q == lc3b_pkg::ST_EX)
				pc_q <= pc2;
			if (f_wr && fin) rf_q[f_idx] <= f_val;
			if (f_cc && fin) cc_q <= lc3b_pkg::flags_of(f_val);
			if (fin) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q) else $error("halt flag dropped");
	a_no_req_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lc3b_pkg::ST_CLEAR) |-> !req_ready) else $error("request during clear");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && state_q != lc3b_pkg::ST_IDLE) |-> (!rsp_valid_q || $past(rsp_valid_q && rsp_ready) || rsp_ready))
		else $error("result overwrote pending word");
`endif

endmodule

// ----- dv/lc3b_instruction_step_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3b_instruction_step_tb
// Runs short LC-3b programs on the core and compares every response word
// against an instruction-level prediction kept inside a scoreboard class.
// ----------------------------------------------------------------------------
module lc3b_instruction_step_tb;

	localparam int MEM_WORDS = 32768;
	localparam longint LIMIT = 3000000;

	class isa_scoreboard;
		logic [15:0] mem [MEM_WORDS];
		logic [15:0] regs [8];
		logic [15:0] pc;
		logic [2:0]  cc;
		bit          started;
		bit          stopped;
		logic [15:0] start_pc;
		lc3b_pkg::out_t pending [$];
		int          errors;

		function void clear();
			foreach (mem[i]) mem[i] = '0;
			foreach (regs[i]) regs[i] = '0;
			pc = '0;
			cc = lc3b_pkg::CC_RESET;
			started = 0;
			stopped = 0;
			start_pc = '0;
			errors = 0;
		endfunction

		function logic [15:0] sx(logic [15:0] v, int bits);
			logic [15:0] m;
			m = 16'((32'h1 << bits) - 32'h1);
			v &= m;
			if (v[bits-1]) v |= ~m;
			return v;
		endfunction

		function int widx(logic [15:0] a);
			return (a >> 1) % MEM_WORDS;
		endfunction

		function logic [2:0] nzp(logic [15:0] v);
			if (v == 0) return 3'b010;
			return v[15] ? 3'b100 : 3'b001;
		endfunction

		function void note_word(lc3b_pkg::in_t w);
			lc3b_pkg::out_t o;
			logic [15:0] ins, pc2, base, op2, ea, t, dv;
			logic [2:0] dr;
			logic [3:0] amt;
			bit wr, scc;
			int wi;
			o = '0;
			wr = 0;
			scc = 0;
			dv = '0;
			if (w.req_type == lc3b_pkg::REQ_WR) begin
				mem[widx(w.byte_address)] = w.write_word;
			end else if (w.req_type == lc3b_pkg::REQ_RD) begin
				o.read_word = mem[widx(w.byte_address)];
			end else if (w.req_type == lc3b_pkg::REQ_STEP) begin
				if (!started) begin
					started = 1;
					pc = start_pc;
				end
				if (pc == 0) stopped = 1;
				if (!stopped) begin
					ins = mem[widx(pc)];
					pc2 = pc + 16'd2;
					pc = pc2;
					dr = ins[11:9];
					base = regs[ins[8:6]];
					op2 = ins[5] ? sx(ins, 5) : regs[ins[2:0]];
					case (ins[15:12])
						lc3b_pkg::OP_ADD: begin dv = base + op2; wr = 1; scc = 1; end
						lc3b_pkg::OP_AND: begin dv = base & op2; wr = 1; scc = 1; end
						lc3b_pkg::OP_XOR: begin dv = base ^ op2; wr = 1; scc = 1; end
						lc3b_pkg::OP_LDB: begin
							ea = base + sx(ins, 6);
							t = mem[widx(ea)];
							t = ea[0] ? (t >> 8) : (t & 16'hFF);
							dv = sx(t, 8); wr = 1; scc = 1;
						end
						lc3b_pkg::OP_LDW: begin
							ea = base + (sx(ins, 6) << 1);
							dv = mem[widx(ea)]; wr = 1; scc = 1;
						end
						lc3b_pkg::OP_STB: begin
							ea = base + sx(ins, 6);
							wi = widx(ea);
							if (ea[0]) mem[wi][15:8] = regs[dr][7:0];
							else mem[wi][7:0] = regs[dr][7:0];
						end
						lc3b_pkg::OP_STW: begin
							ea = base + (sx(ins, 6) << 1);
							mem[widx(ea)] = regs[dr];
						end
						lc3b_pkg::OP_BR: if (dr & cc) pc = pc2 + (sx(ins, 9) << 1);
						lc3b_pkg::OP_JSR: begin
							pc = ins[11] ? pc2 + (sx(ins, 11) << 1) : base;
							dr = lc3b_pkg::REG_LINK; dv = pc2; wr = 1;
						end
						lc3b_pkg::OP_JMP: pc = base;
						lc3b_pkg::OP_SHF: begin
							amt = ins[3:0];
							if (!ins[4]) dv = base << amt;
							else if (!ins[5]) dv = base >> amt;
							else dv = $signed(base) >>> amt;
							wr = 1; scc = 1;
						end
						lc3b_pkg::OP_LEA: begin dv = pc2 + (sx(ins, 9) << 1); wr = 1; end
						lc3b_pkg::OP_TRAP: begin
							pc = mem[ins[7:0] % MEM_WORDS];
							dr = lc3b_pkg::REG_LINK; dv = pc2; wr = 1;
						end
						default: ;
					endcase
					if (wr) begin
						regs[dr] = dv;
						o.reg_write = 1; o.reg_index = dr; o.reg_value = dv;
					end
					if (scc) cc = nzp(dv);
					o.fetched_instruction = ins;
				end
			end
			o.next_pc = pc;
			o.halted = stopped;
			o.cc_nzp = cc;
			pending.push_back(o);
		endfunction

		function void check_word(lc3b_pkg::out_t a);
			lc3b_pkg::out_t e;
			if (pending.size() == 0) begin
				$error("response word with none expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.next_pc !== e.next_pc) begin
				$error("next_pc exp %h got %h", e.next_pc, a.next_pc); errors++;
			end
			if (a.halted !== e.halted) begin
				$error("halted exp %b got %b", e.halted, a.halted); errors++;
			end
			if (a.fetched_instruction !== e.fetched_instruction) begin
				$error("fetched_instruction exp %h got %h", e.fetched_instruction,
					a.fetched_instruction); errors++;
			end
			if (a.reg_write !== e.reg_write) begin
				$error("reg_write exp %b got %b", e.reg_write, a.reg_write); errors++;
			end
			if (a.reg_index !== e.reg_index) begin
				$error("reg_index exp %d got %d", e.reg_index, a.reg_index); errors++;
			end
			if (a.reg_value !== e.reg_value) begin
				$error("reg_value exp %h got %h", e.reg_value, a.reg_value); errors++;
			end
			if (a.cc_nzp !== e.cc_nzp) begin
				$error("cc_nzp exp %b got %b", e.cc_nzp, a.cc_nzp); errors++;
			end
			if (a.read_word !== e.read_word) begin
				$error("read_word exp %h got %h", e.read_word, a.read_word); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic req_valid, req_ready, rsp_valid, rsp_ready;
	lc3b_pkg::in_t req;
	lc3b_pkg::out_t rsp;
	logic psel, penable, pwrite, pready;
	logic [1:0] paddr;
	logic [31:0] pwdata, prdata;

	isa_scoreboard sb;
	longint cycles;
	int burst_left;
	int stall_mode;

	lc3b_instruction_step uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) sb.check_word(rsp);
	end

	// receiver stall pattern: phases of free running, light and heavy stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= ($urandom_range(0, 3) != 0);
				default: rsp_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic send_word(logic [1:0] t, logic [15:0] a, logic [15:0] d);
		lc3b_pkg::in_t w;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		w.req_type = t;
		w.byte_address = a;
		w.write_word = d;
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_word(w);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_start_pc(logic [15:0] v);
		psel <= 1; pwrite <= 1; paddr <= lc3b_pkg::ADDR_START_PC; pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.start_pc = v;
	endtask

	function automatic logic [15:0] rand_instr();
		logic [15:0] i;
		i = 16'($urandom_range(0, 16'hFFFF));
		// turn about one in four instructions into a branch
		if ($urandom_range(0, 3) == 0) i[15:12] = lc3b_pkg::OP_BR;
		return i;
	endfunction

	// load a random program at base, then run it with a few host accesses
	task automatic run_program(logic [15:0] base, int len, int nsteps);
		logic [15:0] a;
		for (int k = 0; k < len; k++)
			send_word(lc3b_pkg::REQ_WR, 16'(base + 2 * k), rand_instr());
		for (int k = 0; k < 16; k++)
			if ($urandom_range(0, 1))
				send_word(lc3b_pkg::REQ_WR, 16'(2 * k), 16'($urandom_range(0, 16'hFFFF)));
		for (int k = 0; k < nsteps; k++) begin
			case ($urandom_range(0, 9))
				0: send_word(lc3b_pkg::REQ_RD, 16'($urandom_range(0, 16'hFFFF)),
					16'($urandom_range(0, 16'hFFFF)));
				1: send_word(lc3b_pkg::REQ_WR, 16'($urandom_range(0, 16'hFFFF)),
					16'($urandom_range(0, 16'hFFFF)));
				2: send_word(2'd3, 16'($urandom_range(0, 16'hFFFF)),
					16'($urandom_range(0, 16'hFFFF)));
				default: send_word(lc3b_pkg::REQ_STEP, 16'd0, 16'd0);
			endcase
		end
		for (int k = 0; k < 4; k++) begin
			a = 16'(base + 2 * $urandom_range(0, len - 1));
			send_word(lc3b_pkg::REQ_RD, a, 16'd0);
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_ready = 1;
		stall_mode = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: host access extremes, unused request, every opcode in lc3b_pkg and RTI
		write_start_pc(16'h0100);
		send_word(lc3b_pkg::REQ_WR, 16'hFFFF, 16'hFFFF);
		send_word(lc3b_pkg::REQ_RD, 16'hFFFE, 16'h0000);
		send_word(lc3b_pkg::REQ_RD, 16'h0001, 16'hFFFF);
		send_word(2'd3, 16'h1234, 16'h5678);
		send_word(lc3b_pkg::REQ_WR, 16'h0100, 16'h1263); // ADD R1,R1,#3
		send_word(lc3b_pkg::REQ_WR, 16'h0102, 16'h5A7F); // AND R5,R1,#-1
		send_word(lc3b_pkg::REQ_WR, 16'h0104, 16'h967F); // NOT R3,R1
		send_word(lc3b_pkg::REQ_WR, 16'h0106, 16'hD6FF); // SHF RSHFA R3 by 15
		send_word(lc3b_pkg::REQ_WR, 16'h0108, 16'hE5FF); // LEA R2 back
		send_word(lc3b_pkg::REQ_WR, 16'h010A, 16'h3681); // STB R3,R2,#1
		send_word(lc3b_pkg::REQ_WR, 16'h010C, 16'h6880); // LDW R4,R2,#0
		send_word(lc3b_pkg::REQ_WR, 16'h010E, 16'h2A81); // LDB R5,R2,#1
		send_word(lc3b_pkg::REQ_WR, 16'h0110, 16'h7A82); // STW R5,R2,#2
		send_word(lc3b_pkg::REQ_WR, 16'h0112, 16'h8000); // RTI, reserved
		send_word(lc3b_pkg::REQ_WR, 16'h0114, 16'h4801); // JSR +1
		send_word(lc3b_pkg::REQ_WR, 16'h0118, 16'hF005); // TRAP x05
		send_word(lc3b_pkg::REQ_WR, 16'h000A, 16'h0120);
		send_word(lc3b_pkg::REQ_WR, 16'h0120, 16'h41C0); // JSRR R7
		send_word(lc3b_pkg::REQ_WR, 16'h011E, 16'h0E00); // BRnzp +0
		send_word(lc3b_pkg::REQ_WR, 16'h0120, 16'hC040); // JMP R1, with R1=3
		for (int k = 0; k < 14; k++) send_word(lc3b_pkg::REQ_STEP, 16'd0, 16'd0);
		drain();

		for (int p = 0; p < 30; p++) begin
			// a new start_pc does not restart: pc only reloads before the first step
			write_start_pc(p == 0 ? 16'hFFFE : p == 1 ? 16'h0000 :
				16'(16'h0200 + 16'h0100 * $urandom_range(0, 32)));
			if (p % 7 == 3) drain();
			run_program(sb.started ? sb.pc : sb.start_pc, $urandom_range(4, 24),
				$urandom_range(20, 50));
			drain();
		end

		drain();
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/lc3b_pkg.sv
hdl/lc3b_instruction_step.sv
dv/lc3b_instruction_step_tb.sv
